// ----- rtl/core/rpm_zone_and_rate_monitor_top_macros.svh -----
// Assertion macros for the rpm zone and rate monitor.
// Uses the enclosing module's clk and rst_n; no other dependencies.
`ifndef RPM_ZONE_AND_RATE_MONITOR_TOP_MACROS_SVH
`define RPM_ZONE_AND_RATE_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define RPMZRM_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define RPMZRM_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rpmzrm_pkg.sv -----
// Shared types and constants for the rpm zone and rate monitor.
// No dependencies; used by every module of the block.
package rpmzrm_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RPM        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_LOW_RPM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_HIGH_RPM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_PERIOD_US = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_WINDOW_US = 3'd5;

  // Register widths and reset values.
  localparam int RPM_W = 16;
  localparam int PER_W = 24;
  localparam logic signed [RPM_W-1:0] RST_MIN_RPM       = 16'sd800;
  localparam logic signed [RPM_W-1:0] RST_NORM_LOW_RPM  = 16'sd1500;
  localparam logic signed [RPM_W-1:0] RST_NORM_HIGH_RPM = 16'sd5000;
  localparam logic signed [RPM_W-1:0] RST_MAX_RPM       = 16'sd7000;
  localparam logic [PER_W-1:0] RST_ZONE_PERIOD_US = 24'd100000;
  localparam logic [PER_W-1:0] RST_RATE_WINDOW_US = 24'd100000;

  // Input and result codes.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;
  localparam logic KIND_ZONE   = 1'b0;
  localparam logic KIND_RATE   = 1'b1;

  localparam int ZONE_W = 3;
  localparam logic [ZONE_W-1:0] ZONE_BELOW_MIN  = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_BELOW_NORM = 3'd1;
  localparam logic [ZONE_W-1:0] ZONE_NORM       = 3'd2;
  localparam logic [ZONE_W-1:0] ZONE_ABOVE_NORM = 3'd3;
  localparam logic [ZONE_W-1:0] ZONE_ABOVE_MAX  = 3'd4;
  localparam logic [ZONE_W-1:0] ZONE_UNSET      = 3'd5;

  // Rate output saturation.
  localparam int RATE_W = 27;
  localparam logic [RATE_W-1:0] RATE_POS_MAX = 27'h3FFFFFF;
  localparam logic [RATE_W-1:0] RATE_NEG_MIN = 27'h4000000;

  // Shared arithmetic unit sizing.
  localparam int ACC_W     = 40;  // 24 x 16 product
  localparam int DIVD_W    = 36;  // 65535 * 1e6 fits in 36 bits
  localparam int MUL_B_W   = 16;  // multiplier bits, one per step
  localparam int WT_W      = ACC_W - 8;  // Q8.8 product after dropping the fraction
  localparam int CNT_W     = 6;
  localparam logic [CNT_W-1:0] MUL_LAST = 6'd15;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd35;
  localparam logic [PER_W-1:0] US_PER_S = 24'd1000000;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  typedef struct packed {
    logic signed [RPM_W-1:0] min_rpm;
    logic signed [RPM_W-1:0] norm_low;
    logic signed [RPM_W-1:0] norm_high;
    logic signed [RPM_W-1:0] max_rpm;
  } bounds_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TICK  = 7'b0000010,
    ST_ZEMIT = 7'b0000100,
    ST_RMUL  = 7'b0001000,
    ST_RDIV  = 7'b0010000,
    ST_REMIT = 7'b0100000,
    ST_WMUL  = 7'b1000000
  } state_t;

endpackage

// ----- rtl/core/rpm_zone_and_rate_monitor_top.sv -----
// Top level of the rpm zone and rate monitor: sequencer, timers, config
// registers and output register. Depends on rpmzrm_pkg, rpmzrm_alu, rpmzrm_zone.
//
// Input stream: each transaction is either a tick (in_tuser low) carrying an
// rpm sample and elapsed microseconds, or a measure request (in_tuser high)
// carrying an rpm sample and a Q8.8 window multiplier. in_tready is high only
// while the sequencer is idle; one transaction is worked on at a time.
// A tick with no result passes through the tick state back to idle. A tick
// that reports a zone adds a state for loading the output register. A tick
// that closes a rate window runs the shared unit twice: a 16-step multiply by
// one million and a 36-step restoring divide. A measure request runs a
// 16-step multiply for the window target. A new transaction is not taken
// until these steps of the shared adder are done.
// Output stream: zone reports (out_tuser low) and rate results (out_tuser
// high); out_tlast marks the final result of one tick. The output register
// lets the sequencer finish work while a result waits; if the receiver
// stalls with a second result pending, the sequencer holds until it is free.
// Reset (rst_n low, synchronous) restores the register defaults, leaves the
// zone unclassified, stops any window and empties the output register.
// Configuration writes are taken at any edge with cfg_we high.
`include "rpm_zone_and_rate_monitor_top_macros.svh"

module rpm_zone_and_rate_monitor_top #(
  parameter int TIME_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // rpm[15:0], elapsed_us[31:16], time_mult[47:32]
  input  logic        in_tuser,    // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // zone[2:0], rate[29:3], falling[30], zero[31]
  output logic        out_tuser,   // kind
  output logic        out_tlast
);

  localparam int CMP_W = (TIME_BITS > rpmzrm_pkg::PER_W) ? TIME_BITS : rpmzrm_pkg::PER_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Configuration registers.
  logic signed [15:0] min_rpm_r, norm_low_r, norm_high_r, max_rpm_r;
  logic [23:0]        zone_period_r, rate_window_r;

  // Block state.
  rpmzrm_pkg::state_t                   state_r, state_nxt;
  logic [rpmzrm_pkg::ZONE_W-1:0]        cur_zone_r, cur_zone_nxt;
  logic [TIME_BITS-1:0]                 zone_el_r, zone_el_nxt;
  logic                                 measuring_r, measuring_nxt;
  logic [TIME_BITS-1:0]                 win_el_r, win_el_nxt;
  logic [TIME_BITS-1:0]                 win_tgt_r, win_tgt_nxt;
  logic signed [15:0]                   first_r, first_nxt;
  logic                                 rate_pend_r, rate_pend_nxt;

  // Latched transaction payload.
  logic signed [15:0] rpm_r;
  logic [15:0]        dt_r, mult_r;

  // Output register.
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_kind_r, out_kind_nxt;
  logic [rpmzrm_pkg::ZONE_W-1:0]    out_zone_r, out_zone_nxt;
  logic [rpmzrm_pkg::RATE_W-1:0]    out_rate_r, out_rate_nxt;
  logic                             out_fall_r, out_fall_nxt;
  logic                             out_last_r, out_last_nxt;

  logic in_acc;
  logic out_free;
  logic load_out;

  // Shared unit and zone checker wiring.
  rpmzrm_pkg::alu_ctl_t            alu_ctl;
  rpmzrm_pkg::alu_sts_t            alu_sts;
  logic [rpmzrm_pkg::ACC_W-1:0]    alu_opa;
  logic [rpmzrm_pkg::DIVD_W-1:0]   alu_opb;
  logic [rpmzrm_pkg::ACC_W-1:0]    alu_prod;
  logic [rpmzrm_pkg::DIVD_W-1:0]   alu_quot;
  rpmzrm_pkg::bounds_t             bounds;
  logic                            zone_left;
  logic [rpmzrm_pkg::ZONE_W-1:0]   zone_class;

  // Timer and rate helpers.
  logic [TIME_BITS:0]              ze_sum, we_sum;
  logic [TIME_BITS-1:0]            ze_new, we_new;
  logic                            zone_hit, rate_hit;
  logic signed [16:0]              diff, diff_neg;
  logic [15:0]                     diff_mag;
  logic                            diff_lt0;
  logic [TIME_BITS-1:0]            divisor;
  logic [rpmzrm_pkg::WT_W-1:0]     tgt_full;
  logic [TIME_BITS-1:0]            tgt_new;
  logic [rpmzrm_pkg::RATE_W-1:0]   rate_val;

  assign in_tready = (state_r == rpmzrm_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign bounds.min_rpm   = min_rpm_r;
  assign bounds.norm_low  = norm_low_r;
  assign bounds.norm_high = norm_high_r;
  assign bounds.max_rpm   = max_rpm_r;

  rpmzrm_zone u_zone (
    .rpm      (rpm_r),
    .cur_zone (cur_zone_r),
    .bounds   (bounds),
    .left     (zone_left),
    .new_zone (zone_class)
  );

  rpmzrm_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .opa   (alu_opa),
    .opb   (alu_opb),
    .sts   (alu_sts),
    .prod  (alu_prod),
    .quot  (alu_quot)
  );

  // Saturating timer updates for a tick.
  always_comb begin
    ze_sum   = {1'b0, zone_el_r} + (TIME_BITS + 1)'(dt_r);
    ze_new   = ze_sum[TIME_BITS] ? TIME_MAX : ze_sum[TIME_BITS-1:0];
    zone_hit = CMP_W'(ze_new) >= CMP_W'(zone_period_r);
    we_sum   = {1'b0, win_el_r} + (TIME_BITS + 1)'(dt_r);
    we_new   = we_sum[TIME_BITS] ? TIME_MAX : we_sum[TIME_BITS-1:0];
    rate_hit = measuring_r && (we_new >= win_tgt_r);
  end

  // Rpm difference over the window, as sign and magnitude.
  always_comb begin
    diff     = {rpm_r[15], rpm_r} - {first_r[15], first_r};
    diff_neg = -diff;
    diff_lt0 = diff[16];
    diff_mag = diff_lt0 ? diff_neg[15:0] : diff[15:0];
    divisor  = (win_tgt_r == '0) ? TIME_BITS'(1) : win_tgt_r;
  end

  // Window target from the Q8.8 product, saturated to the timer width.
  always_comb begin
    tgt_full = alu_prod[rpmzrm_pkg::ACC_W-1:8];
    tgt_new  = (tgt_full > rpmzrm_pkg::WT_W'(TIME_MAX)) ? TIME_MAX
                                                      : tgt_full[TIME_BITS-1:0];
  end

  // Signed, saturated rate from the quotient magnitude.
  always_comb begin
    if (diff_lt0) begin
      if (alu_quot > rpmzrm_pkg::DIVD_W'(rpmzrm_pkg::RATE_NEG_MIN)) begin
        rate_val = rpmzrm_pkg::RATE_NEG_MIN;
      end else begin
        rate_val = -alu_quot[rpmzrm_pkg::RATE_W-1:0];
      end
    end else begin
      if (alu_quot > rpmzrm_pkg::DIVD_W'(rpmzrm_pkg::RATE_POS_MAX)) begin
        rate_val = rpmzrm_pkg::RATE_POS_MAX;
      end else begin
        rate_val = alu_quot[rpmzrm_pkg::RATE_W-1:0];
      end
    end
  end

  // Shared unit requests: start once on entering a compute state.
  always_comb begin
    alu_ctl.start = 1'b0;
    alu_ctl.op    = rpmzrm_pkg::ALU_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    case (state_r)
      rpmzrm_pkg::ST_RMUL: begin
        alu_ctl.start = !alu_sts.busy && !alu_sts.done;
        alu_opa       = rpmzrm_pkg::ACC_W'(rpmzrm_pkg::US_PER_S);
        alu_opb       = rpmzrm_pkg::DIVD_W'(diff_mag);
      end
      rpmzrm_pkg::ST_RDIV: begin
        alu_ctl.start = !alu_sts.busy && !alu_sts.done;
        alu_ctl.op    = rpmzrm_pkg::ALU_DIV;
        alu_opa       = rpmzrm_pkg::ACC_W'(divisor);
        alu_opb       = alu_prod[rpmzrm_pkg::DIVD_W-1:0];
      end
      rpmzrm_pkg::ST_WMUL: begin
        alu_ctl.start = !alu_sts.busy && !alu_sts.done;
        alu_opa       = rpmzrm_pkg::ACC_W'(rate_window_r);
        alu_opb       = rpmzrm_pkg::DIVD_W'(mult_r);
      end
      default: begin
        alu_ctl.start = 1'b0;
      end
    endcase
  end

  // Sequencer and state updates.
  always_comb begin
    state_nxt     = state_r;
    cur_zone_nxt  = cur_zone_r;
    zone_el_nxt   = zone_el_r;
    measuring_nxt = measuring_r;
    win_el_nxt    = win_el_r;
    win_tgt_nxt   = win_tgt_r;
    first_nxt     = first_r;
    rate_pend_nxt = rate_pend_r;
    load_out      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_zone_nxt  = out_zone_r;
    out_rate_nxt  = out_rate_r;
    out_fall_nxt  = out_fall_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      rpmzrm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == rpmzrm_pkg::CMD_MEASURE) ? rpmzrm_pkg::ST_WMUL
                                                            : rpmzrm_pkg::ST_TICK;
        end
      end
      rpmzrm_pkg::ST_TICK: begin
        zone_el_nxt   = zone_hit ? '0 : ze_new;
        if (measuring_r) begin
          win_el_nxt = we_new;
        end
        rate_pend_nxt = rate_hit;
        if (zone_hit && zone_left) begin
          cur_zone_nxt = zone_class;
          state_nxt    = rpmzrm_pkg::ST_ZEMIT;
        end else if (rate_hit) begin
          state_nxt = rpmzrm_pkg::ST_RMUL;
        end else begin
          state_nxt = rpmzrm_pkg::ST_IDLE;
        end
      end
      rpmzrm_pkg::ST_ZEMIT: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_kind_nxt = rpmzrm_pkg::KIND_ZONE;
          out_zone_nxt = cur_zone_r;
          out_rate_nxt = '0;
          out_fall_nxt = 1'b0;
          out_last_nxt = !rate_pend_r;
          state_nxt    = rate_pend_r ? rpmzrm_pkg::ST_RMUL : rpmzrm_pkg::ST_IDLE;
        end
      end
      rpmzrm_pkg::ST_RMUL: begin
        if (alu_sts.done) begin
          state_nxt = rpmzrm_pkg::ST_RDIV;
        end
      end
      rpmzrm_pkg::ST_RDIV: begin
        if (alu_sts.done) begin
          state_nxt = rpmzrm_pkg::ST_REMIT;
        end
      end
      rpmzrm_pkg::ST_REMIT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_kind_nxt  = rpmzrm_pkg::KIND_RATE;
          out_zone_nxt  = rpmzrm_pkg::ZONE_BELOW_MIN;
          out_rate_nxt  = rate_val;
          out_fall_nxt  = diff_lt0;
          out_last_nxt  = 1'b1;
          measuring_nxt = 1'b0;
          state_nxt     = rpmzrm_pkg::ST_IDLE;
        end
      end
      rpmzrm_pkg::ST_WMUL: begin
        if (alu_sts.done) begin
          if (measuring_r) begin
            // A running window can only be shortened.
            if (win_tgt_r > tgt_new) begin
              win_tgt_nxt = tgt_new;
            end
          end else begin
            first_nxt     = rpm_r;
            win_tgt_nxt   = tgt_new;
            win_el_nxt    = '0;
            measuring_nxt = 1'b1;
          end
          state_nxt = rpmzrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rpmzrm_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared once the transaction completes.
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rpm_r     <= rpmzrm_pkg::RST_MIN_RPM;
      norm_low_r    <= rpmzrm_pkg::RST_NORM_LOW_RPM;
      norm_high_r   <= rpmzrm_pkg::RST_NORM_HIGH_RPM;
      max_rpm_r     <= rpmzrm_pkg::RST_MAX_RPM;
      zone_period_r <= rpmzrm_pkg::RST_ZONE_PERIOD_US;
      rate_window_r <= rpmzrm_pkg::RST_RATE_WINDOW_US;
    end else if (cfg_we) begin
      case (cfg_index)
        rpmzrm_pkg::REG_MIN_RPM:        min_rpm_r     <= cfg_wdata[15:0];
        rpmzrm_pkg::REG_NORM_LOW_RPM:   norm_low_r    <= cfg_wdata[15:0];
        rpmzrm_pkg::REG_NORM_HIGH_RPM:  norm_high_r   <= cfg_wdata[15:0];
        rpmzrm_pkg::REG_MAX_RPM:        max_rpm_r     <= cfg_wdata[15:0];
        rpmzrm_pkg::REG_ZONE_PERIOD_US: zone_period_r <= cfg_wdata;
        rpmzrm_pkg::REG_RATE_WINDOW_US: rate_window_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Control and model state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpmzrm_pkg::ST_IDLE;
      cur_zone_r  <= rpmzrm_pkg::ZONE_UNSET;
      zone_el_r   <= '0;
      measuring_r <= 1'b0;
      win_el_r    <= '0;
      win_tgt_r   <= '0;
      first_r     <= '0;
      rate_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_zone_r  <= cur_zone_nxt;
      zone_el_r   <= zone_el_nxt;
      measuring_r <= measuring_nxt;
      win_el_r    <= win_el_nxt;
      win_tgt_r   <= win_tgt_nxt;
      first_r     <= first_nxt;
      rate_pend_r <= rate_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rpm_r  <= in_tdata[15:0];
      dt_r   <= in_tdata[31:16];
      mult_r <= in_tdata[47:32];
    end
    out_kind_r <= out_kind_nxt;
    out_zone_r <= out_zone_nxt;
    out_rate_r <= out_rate_nxt;
    out_fall_r <= out_fall_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_fall_r, out_rate_r, out_zone_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Checks on the sequencer and result formatting.
  `RPMZRM_CHK(a_rate_is_last, out_tvalid && (out_tuser == rpmzrm_pkg::KIND_RATE), out_tlast, "rate result without tlast")
  `RPMZRM_CHK(a_zone_fmt, out_tvalid && (out_tuser == rpmzrm_pkg::KIND_ZONE), (out_tdata[2:0] <= rpmzrm_pkg::ZONE_ABOVE_MAX) && (out_tdata[31:3] == '0), "malformed zone report")
  `RPMZRM_CHK(a_alu_owner, alu_sts.busy || alu_sts.done, (state_r == rpmzrm_pkg::ST_RMUL) || (state_r == rpmzrm_pkg::ST_RDIV) || (state_r == rpmzrm_pkg::ST_WMUL), "shared unit active outside a compute state")
  `RPMZRM_CHK_NEXT(a_rate_loaded, (state_r == rpmzrm_pkg::ST_REMIT) && out_free, out_tvalid && (out_tuser == rpmzrm_pkg::KIND_RATE) && !measuring_r, "rate result not presented")

endmodule

// ----- rtl/core/rpmzrm_alu.sv -----
// Shared iterative arithmetic unit: shift-add multiply and restoring divide
// on one adder, one bit per cycle. Depends on rpmzrm_pkg.
module rpmzrm_alu #(
  parameter int TIME_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rpmzrm_pkg::alu_ctl_t            ctl,
  input  logic [rpmzrm_pkg::ACC_W-1:0]    opa,   // multiplicand or divisor
  input  logic [rpmzrm_pkg::DIVD_W-1:0]   opb,   // multiplier or dividend
  output rpmzrm_pkg::alu_sts_t            sts,
  output logic [rpmzrm_pkg::ACC_W-1:0]    prod,
  output logic [rpmzrm_pkg::DIVD_W-1:0]   quot
);

  logic [rpmzrm_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [rpmzrm_pkg::DIVD_W-1:0] sh_r, sh_nxt;
  logic [rpmzrm_pkg::ACC_W-1:0]  opnd_r, opnd_nxt;
  logic [rpmzrm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  rpmzrm_pkg::alu_op_t           op_r, op_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;

  logic [TIME_BITS:0]            rem_sh;
  logic [rpmzrm_pkg::ACC_W-1:0]  add_a, add_b;
  logic                          add_sub;
  logic [rpmzrm_pkg::ACC_W:0]    sum;
  logic                          geq;

  // Operand selection for the one shared adder.
  always_comb begin
    rem_sh = {acc_r[TIME_BITS-1:0], sh_r[rpmzrm_pkg::DIVD_W-1]};
    if (op_r == rpmzrm_pkg::ALU_MUL) begin
      add_a   = {acc_r[rpmzrm_pkg::ACC_W-2:0], 1'b0};
      add_b   = sh_r[rpmzrm_pkg::DIVD_W-1] ? opnd_r : '0;
      add_sub = 1'b0;
    end else begin
      add_a   = rpmzrm_pkg::ACC_W'(rem_sh);
      add_b   = opnd_r;
      add_sub = 1'b1;
    end
    sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
          + (rpmzrm_pkg::ACC_W + 1)'(add_sub);
    // With subtraction, the carry out means the remainder covers the divisor.
    geq = sum[rpmzrm_pkg::ACC_W];
  end

  // Step control: load on start, then one bit per cycle.
  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    opnd_nxt = opnd_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start && !busy_r) begin
      acc_nxt  = '0;
      opnd_nxt = opa;
      op_nxt   = ctl.op;
      busy_nxt = 1'b1;
      if (ctl.op == rpmzrm_pkg::ALU_MUL) begin
        sh_nxt  = {opb[rpmzrm_pkg::MUL_B_W-1:0],
                   {(rpmzrm_pkg::DIVD_W - rpmzrm_pkg::MUL_B_W){1'b0}}};
        cnt_nxt = rpmzrm_pkg::MUL_LAST;
      end else begin
        sh_nxt  = opb;
        cnt_nxt = rpmzrm_pkg::DIV_LAST;
      end
    end else if (busy_r) begin
      if (op_r == rpmzrm_pkg::ALU_MUL) begin
        acc_nxt = sum[rpmzrm_pkg::ACC_W-1:0];
        sh_nxt  = {sh_r[rpmzrm_pkg::DIVD_W-2:0], 1'b0};
      end else begin
        acc_nxt = geq ? sum[rpmzrm_pkg::ACC_W-1:0] : add_a;
        sh_nxt  = {sh_r[rpmzrm_pkg::DIVD_W-2:0], geq};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    sh_r   <= sh_nxt;
    opnd_r <= opnd_nxt;
    cnt_r  <= cnt_nxt;
    op_r   <= op_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r;
  assign quot     = sh_r;

endmodule

// ----- rtl/core/rpmzrm_zone.sv -----
// Zone bound checks: whether the rpm has left the current zone and which
// zone it falls in now. Depends on rpmzrm_pkg.
module rpmzrm_zone (
  input  logic signed [rpmzrm_pkg::RPM_W-1:0]  rpm,
  input  logic [rpmzrm_pkg::ZONE_W-1:0]        cur_zone,
  input  rpmzrm_pkg::bounds_t                  bounds,
  output logic                                 left,
  output logic [rpmzrm_pkg::ZONE_W-1:0]        new_zone
);

  logic signed [rpmzrm_pkg::RPM_W-1:0] mn, nl, nh, mx;
  logic gt_mn, lt_mn, gt_nl, lt_nl, gt_nh, lt_nh, gt_mx, lt_mx;

  assign mn = bounds.min_rpm;
  assign nl = bounds.norm_low;
  assign nh = bounds.norm_high;
  assign mx = bounds.max_rpm;

  // One signed compare per bound and direction; equality stays inside.
  assign gt_mn = rpm > mn;
  assign lt_mn = rpm < mn;
  assign gt_nl = rpm > nl;
  assign lt_nl = rpm < nl;
  assign gt_nh = rpm > nh;
  assign lt_nh = rpm < nh;
  assign gt_mx = rpm > mx;
  assign lt_mx = rpm < mx;

  // Has the sample strictly left the bounds of the current zone?
  always_comb begin
    case (cur_zone)
      rpmzrm_pkg::ZONE_BELOW_MIN:  left = gt_mn;
      rpmzrm_pkg::ZONE_BELOW_NORM: left = lt_mn || gt_nl;
      rpmzrm_pkg::ZONE_NORM:       left = lt_nl || gt_nh;
      rpmzrm_pkg::ZONE_ABOVE_NORM: left = lt_nh || gt_mx;
      rpmzrm_pkg::ZONE_ABOVE_MAX:  left = lt_mx;
      default:                     left = 1'b1;
    endcase
  end

  // Classification, upper side tested first.
  always_comb begin
    if (gt_nh) begin
      new_zone = gt_mx ? rpmzrm_pkg::ZONE_ABOVE_MAX : rpmzrm_pkg::ZONE_ABOVE_NORM;
    end else if (lt_nl) begin
      new_zone = lt_mn ? rpmzrm_pkg::ZONE_BELOW_MIN : rpmzrm_pkg::ZONE_BELOW_NORM;
    end else begin
      new_zone = rpmzrm_pkg::ZONE_NORM;
    end
  end

endmodule

// ----- sim/tb_rpm_zone_and_rate_monitor_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for rpm_zone_and_rate_monitor_top: directed and random ticks and
// measure requests, with results checked against an in-bench zone and rate predictor.
// Depends on rpmzrm_pkg and the RTL of the block only.

module tb_rpm_zone_and_rate_monitor_top;
  import rpmzrm_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_SHOWN = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 144;
  localparam longint TIME_SAT = (longint'(1) << 24) - 1;
  localparam longint RATE_HI = longint'(RATE_POS_MAX);
  localparam longint RATE_LO_MAG = RATE_HI + 1;

  typedef struct packed {
    logic              kind;
    logic [ZONE_W-1:0] zone;
    logic [RATE_W-1:0] rate;
    logic              falling;
    logic              last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // rpm[15:0], elapsed_us[31:16], time_mult[47:32]
  logic        in_tuser = 1'b0; // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // zone[2:0], rate[29:3], falling[30], zero[31]
  logic        out_tuser;       // kind
  logic        out_tlast;

  // Predictor copy of the registers and of the block state.
  logic signed [15:0] m_min, m_norm_low, m_norm_high, m_max;
  logic [23:0]        m_zone_period, m_rate_window;
  logic [2:0]         zone_now;
  logic [23:0]        zone_acc;
  logic               measuring;
  logic [23:0]        win_acc, win_target;
  logic signed [15:0] win_first;

  report_t pending_reports[$];
  int err_count = 0;
  int items_sent = 0;
  int reports_checked = 0;
  int rx_hold = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;

  rpm_zone_and_rate_monitor_top #(.TIME_BITS(24)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_monitor_model();
    m_min = RST_MIN_RPM;
    m_norm_low = RST_NORM_LOW_RPM;
    m_norm_high = RST_NORM_HIGH_RPM;
    m_max = RST_MAX_RPM;
    m_zone_period = RST_ZONE_PERIOD_US;
    m_rate_window = RST_RATE_WINDOW_US;
    zone_now = ZONE_UNSET;
    zone_acc = '0;
    measuring = 1'b0;
    win_acc = '0;
    win_target = '0;
    win_first = '0;
  endfunction

  function automatic void set_register(logic [2:0] idx, logic [23:0] val);
    case (idx)
      REG_MIN_RPM:        m_min = val[15:0];
      REG_NORM_LOW_RPM:   m_norm_low = val[15:0];
      REG_NORM_HIGH_RPM:  m_norm_high = val[15:0];
      REG_MAX_RPM:        m_max = val[15:0];
      REG_ZONE_PERIOD_US: m_zone_period = val;
      REG_RATE_WINDOW_US: m_rate_window = val;
      default: ;
    endcase
  endfunction

  function automatic logic [ZONE_W-1:0] zone_of(logic signed [15:0] r);
    if (r > m_norm_high) return (r > m_max) ? ZONE_ABOVE_MAX : ZONE_ABOVE_NORM;
    if (r < m_norm_low) return (r < m_min) ? ZONE_BELOW_MIN : ZONE_BELOW_NORM;
    return ZONE_NORM;
  endfunction

  // A sample equal to a bound of the current zone keeps the zone.
  function automatic bit has_left_zone(logic signed [15:0] r);
    case (zone_now)
      ZONE_BELOW_MIN:  return r > m_min;
      ZONE_BELOW_NORM: return (r < m_min) || (r > m_norm_low);
      ZONE_NORM:       return (r < m_norm_low) || (r > m_norm_high);
      ZONE_ABOVE_NORM: return (r < m_norm_high) || (r > m_max);
      ZONE_ABOVE_MAX:  return r < m_max;
      default:         return 1'b1;
    endcase
  endfunction

  function automatic logic [23:0] sat_time(logic [23:0] acc, logic [15:0] dt);
    longint s;
    s = longint'(acc) + longint'(dt);
    if (s > TIME_SAT) return '1;
    return s[23:0];
  endfunction

  // Advances the predicted state by one accepted transaction and queues its results.
  function automatic void advance_monitor(logic cmd, logic signed [15:0] r, logic [15:0] arg);
    longint  t, diff, mag, rate_v;
    report_t zr, rr;
    bit      got_zone, got_rate;
    got_zone = 1'b0;
    got_rate = 1'b0;
    zr = '0;
    rr = '0;
    if (cmd == CMD_MEASURE) begin
      t = (longint'(m_rate_window) * longint'(arg)) >> 8;
      if (t > TIME_SAT) t = TIME_SAT;
      if (measuring) begin
        if (longint'(win_target) > t) win_target = t[23:0];
      end else begin
        win_first = r;
        win_target = t[23:0];
        win_acc = '0;
        measuring = 1'b1;
      end
    end else begin
      zone_acc = sat_time(zone_acc, arg);
      if (zone_acc >= m_zone_period) begin
        if (has_left_zone(r)) begin
          zone_now = zone_of(r);
          zr.kind = KIND_ZONE;
          zr.zone = zone_now;
          got_zone = 1'b1;
        end
        zone_acc = '0;
      end
      if (measuring) begin
        win_acc = sat_time(win_acc, arg);
        if (win_acc >= win_target) begin
          diff = longint'(r) - longint'(win_first);
          mag = ((diff < 0) ? -diff : diff) * 1000000;
          // A zero target divides by one.
          mag = mag / ((win_target == '0) ? longint'(1) : longint'(win_target));
          if (diff < 0) rate_v = (mag > RATE_LO_MAG) ? -RATE_LO_MAG : -mag;
          else rate_v = (mag > RATE_HI) ? RATE_HI : mag;
          rr.kind = KIND_RATE;
          rr.rate = rate_v[RATE_W-1:0];
          rr.falling = (diff < 0);
          got_rate = 1'b1;
          measuring = 1'b0;
        end
      end
    end
    if (got_zone) begin
      zr.last = !got_rate;
      pending_reports.push_back(zr);
    end
    if (got_rate) begin
      rr.last = 1'b1;
      pending_reports.push_back(rr);
    end
  endfunction

  // ---------------------------------------------------------------- random helpers

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 64);
  endfunction

  function automatic logic signed [15:0] pick_rpm();
    logic signed [15:0] b;
    if ($urandom_range(0, 99) < 60) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: b = m_min;
      1: b = m_norm_low;
      2: b = m_norm_high;
      default: b = m_max;
    endcase
    return b + 16'($signed($urandom_range(0, 2)) - 1);
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 16'($urandom_range(0, 65535));
    if (p < 90) return 16'($urandom_range(0, 1500));
    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic logic [15:0] pick_mult();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 16'($urandom_range(1, 512));
    if (p < 90) return 16'($urandom_range(1, 65535));
    return 16'd256;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Each write ends with the enable low at a clock edge, so that the enable is never lowered and raised in one step.
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    set_register(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_bounds(logic signed [15:0] mn, logic signed [15:0] nl,
                              logic signed [15:0] nh, logic signed [15:0] mx);
    write_reg(REG_MIN_RPM, {8'h00, mn});
    write_reg(REG_NORM_LOW_RPM, {8'h00, nl});
    write_reg(REG_NORM_HIGH_RPM, {8'h00, nh});
    write_reg(REG_MAX_RPM, {8'h00, mx});
  endtask

  // Offers one transaction and returns at the edge where it is accepted.
  // The unused field carries random bits.
  task automatic send_item(logic cmd, logic signed [15:0] r, logic [15:0] arg);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    if (cmd == CMD_MEASURE) in_tdata <= {arg, 16'($urandom), r};
    else in_tdata <= {16'($urandom), arg, r};
    do @(posedge clk); while (!in_tready);
    advance_monitor(cmd, r, arg);
    items_sent++;
  endtask

  task automatic send_tick(logic signed [15:0] r, logic [15:0] elapsed);
    send_item(CMD_TICK, r, elapsed);
  endtask

  task automatic send_measure(logic signed [15:0] r, logic [15:0] mult);
    send_item(CMD_MEASURE, r, mult);
  endtask

  // Stops offering, waits for every predicted result, then lets the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin : rx_driver
    int n;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        n = rx_hold;
        rx_hold = 0;
        repeat (n - 1) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 99) < 30) begin
        out_tready <= 1'b0;
        n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(16, 64);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(string what, report_t want, report_t got);
    err_count++;
    if (err_count <= MAX_SHOWN)
      $display("%0t: %s: expected kind=%0d zone=%0d rate=%0d falling=%0d last=%0d, got kind=%0d zone=%0d rate=%0d falling=%0d last=%0d bit31=%0b",
               $time, what, want.kind, want.zone, $signed(want.rate), want.falling, want.last,
               got.kind, got.zone, $signed(got.rate), got.falling, got.last, out_tdata[31]);
  endtask

  always @(posedge clk) begin : check_reports
    report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.zone = out_tdata[2:0];
      got.rate = out_tdata[29:3];
      got.falling = out_tdata[30];
      got.last = out_tlast;
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing expected", '0, got);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (got !== want || out_tdata[31] !== 1'b0) report_mismatch("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // First zone check after reset classifies from the unclassified state.
  task automatic test_reset_defaults();
    send_tick(16'sd3000, 16'd65535);
    send_tick(16'sd3000, 16'd65535);
    wait_idle();
  endtask

  // Samples on and just past every bound, with a check on every tick.
  task automatic test_zone_hysteresis();
    logic signed [15:0] seq [13] = '{16'sd5000, 16'sd5001, 16'sd7000, 16'sd7001, 16'sd7000,
                                     16'sd6999, 16'sd32767, -16'sd32768, 16'sd800, 16'sd801,
                                     16'sd1500, 16'sd1501, 16'sd1499};
    write_reg(REG_ZONE_PERIOD_US, 24'd1001);
    foreach (seq[i]) send_tick(seq[i], 16'd1001);
    // The period is reached by accumulation, and a check with no zone change emits nothing.
    send_tick(16'sd801, 16'd1000);
    send_tick(16'sd801, 16'd1);
    wait_idle();
  endtask

  // A second request shortens a running window; a larger one leaves it alone.
  task automatic test_window_shortening();
    send_measure(16'sd1000, 16'd256);
    send_measure(16'sd1200, 16'd128);
    send_measure(16'sd9999, 16'd512);
    send_tick(16'sd1100, 16'd0);
    send_tick(16'sd1200, 16'd30000);
    send_tick(16'sd500, 16'd30000);
    wait_idle();
  endtask

  // Shortest windows against the widest rpm swings, plus a truncated negative rate.
  task automatic test_rate_extremes();
    write_reg(REG_RATE_WINDOW_US, 24'd1001);
    send_measure(-16'sd32768, 16'd1);
    send_tick(16'sd32767, 16'd2);
    send_tick(16'sd32767, 16'd1);
    send_measure(16'sd32767, 16'd1);
    send_tick(-16'sd32768, 16'd65535);
    send_measure(16'sd0, 16'd65535);
    repeat (4) send_tick(16'sd0, 16'd65535);
    send_measure(16'sd1000, 16'd256);
    send_tick(16'sd999, 16'd1001);
    wait_idle();
  endtask

  // Bounds in reverse order are used exactly as the comparisons see them.
  task automatic test_odd_bounds();
    logic signed [15:0] seq [7] = '{-16'sd32768, -16'sd101, -16'sd100, 16'sd0, 16'sd100,
                                    16'sd101, 16'sd32767};
    write_bounds(16'sd32767, 16'sd100, -16'sd100, -16'sd32768);
    foreach (seq[i]) send_tick(seq[i], 16'd1001);
    wait_idle();
    write_bounds(RST_MIN_RPM, RST_NORM_LOW_RPM, RST_NORM_HIGH_RPM, RST_MAX_RPM);
  endtask

  // Longest period and a saturated window: both timers end by saturating.
  task automatic test_timer_saturation();
    write_reg(REG_ZONE_PERIOD_US, 24'hFFFFFF);
    write_reg(REG_RATE_WINDOW_US, 24'hFFFFFF);
    send_measure(16'sd100, 16'd65535);
    repeat (258) send_tick(16'sd200, 16'd65535);
    wait_idle();
  endtask

  // The receiver holds off while ticks keep producing two results each.
  task automatic test_output_stall();
    int i;
    write_reg(REG_ZONE_PERIOD_US, 24'd1001);
    write_reg(REG_RATE_WINDOW_US, 24'd1001);
    rx_hold = 400;
    for (i = 0; i < 8; i++) begin
      send_measure((i % 2) ? -16'sd32768 : 16'sd32767, 16'd1);
      send_tick((i % 2) ? 16'sd32767 : -16'sd32768, 16'd2000);
    end
    wait_idle();
  endtask

  task automatic configure_phase(int p);
    logic signed [15:0] b [4];
    logic signed [15:0] tmp;
    int pick;
    case ($urandom_range(0, 3))
      0, 1: begin
        foreach (b[i]) b[i] = 16'($urandom);
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3 - i; j++)
            if (b[j] > b[j + 1]) begin
              tmp = b[j];
              b[j] = b[j + 1];
              b[j + 1] = tmp;
            end
      end
      2: b = '{RST_MIN_RPM, RST_NORM_LOW_RPM, RST_NORM_HIGH_RPM, RST_MAX_RPM};
      default: foreach (b[i]) b[i] = 16'($urandom);
    endcase
    write_bounds(b[0], b[1], b[2], b[3]);
    pick = $urandom_range(0, 99);
    if (pick < 60) write_reg(REG_ZONE_PERIOD_US, 24'($urandom_range(1001, 40000)));
    else if (pick < 80) write_reg(REG_ZONE_PERIOD_US, 24'd1001);
    else if (pick < 95) write_reg(REG_ZONE_PERIOD_US, 24'($urandom_range(40000, 300000)));
    else write_reg(REG_ZONE_PERIOD_US, 24'hFFFFFF);
    pick = $urandom_range(0, 99);
    if (pick < 50) write_reg(REG_RATE_WINDOW_US, 24'($urandom_range(1001, 20000)));
    else if (pick < 75) write_reg(REG_RATE_WINDOW_US, 24'd1001);
    else if (pick < 95) write_reg(REG_RATE_WINDOW_US, 24'($urandom_range(20000, 1000000)));
    else write_reg(REG_RATE_WINDOW_US, 24'hFFFFFF);
    // One phase runs back to back on both sides, another only on the output side.
    tx_gaps = (p != 2);
    rx_gaps = (p != 2) && (p != 5);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure_phase(p);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) send_measure(pick_rpm(), pick_mult());
        else send_tick(pick_rpm(), pick_elapsed());
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_monitor_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_reset_defaults();
    test_zone_hysteresis();
    test_window_shortening();
    test_rate_extremes();
    test_odd_bounds();
    test_timer_saturation();
    test_output_stall();
    test_random_phases();
    wait_idle();
    $display("Sent %0d input transactions and checked %0d results, %0d random phases.",
             items_sent, reports_checked, RANDOM_PHASES);
    $display("Covered zone bounds, odd bounds, window shortening, rate and timer saturation, output stall.");
    if (err_count == 0 && pending_reports.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50_000_000;
    $display("Timeout with %0d results still expected.", pending_reports.size());
    $display("status: fail");
    $finish;
  end

endmodule
